>>> sv/rmq_pkg.sv
// Shared constants for the rotation matrix to quaternion pipeline.
package rmq_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int FIELD_W       = 18;
    localparam logic [1:0] CASE_TRACE = 2'd0;
    localparam logic [1:0] CASE_XX    = 2'd1;
    localparam logic [1:0] CASE_YY    = 2'd2;
    localparam logic [1:0] CASE_ZZ    = 2'd3;
endpackage

>>> sv/rotation_matrix_to_quaternion.sv
// Rotation matrix to quaternion converter, top level.
// Pipeline: 3 + SQI + DVW register stages, 57 at FRAC_BITS = 16: two input stages, 19 root
// stages, FRAC_BITS + 19 divider stages and the output register.
// Throughput: one matrix per cycle; a stall at the output freezes the whole pipeline.
// Reset: aresetn, synchronous and active low, clears every stage valid bit.
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // m_xx, m_xy, m_xz, m_yx, m_yy, m_yz, m_zx, m_zy, m_zz from the lowest bit up.
    input  logic [167:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // q_w, q_x, q_y, q_z, case_taken, degenerate from the lowest bit up, zero filled.
    output logic [79:0]   m_tdata
);
    // The radicand stays below 2^(RW-1), so it and the trace fit this signed width.
    localparam int RW  = (FRAC_BITS > 18) ? FRAC_BITS + 2 : 21;
    localparam int SQW = ((RW + FRAC_BITS + 2) / 2) * 2;  // even width of the root operand
    localparam int SQI = (SQW + 1) / 2;             // root iterations and root width
    localparam int NW  = 19;                        // numerator magnitude width
    localparam int DVW = NW + FRAC_BITS;            // quotient bits, one under the dividend width
    localparam int DSW = SQI + 1;                   // width of s = 2r
    localparam int DEP = 2 + SQI + DVW + 1;
    localparam int RMW = DSW + 1;

    // The whole pipe advances together; the output register is the last stage.
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    logic [DEP-1:0] vld_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[DEP-2:0], s_tvalid};
        end
    end
    assign m_tvalid = vld_reg[DEP-1];

    // Stage 1: register inputs.
    logic signed [FIELD_W-1:0] e_reg [9];
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 9; i++) e_reg[i] <= s_tdata[i*FIELD_W +: FIELD_W];
        end
    end

    // Stage 2: trace, branch choice, radicand and numerators.
    logic signed [RW-1:0]  one_c;
    logic signed [RW-1:0]  xx, xy, xz, yx, yy, yz, zx, zy, zz, tr;
    logic signed [RW-1:0]  rad_next;
    logic signed [NW:0]    n_next [3];
    logic [1:0]            sel_next;
    assign one_c = RW'(1) <<< FRAC_BITS;
    assign xx = RW'(e_reg[0]); assign xy = RW'(e_reg[1]); assign xz = RW'(e_reg[2]);
    assign yx = RW'(e_reg[3]); assign yy = RW'(e_reg[4]); assign yz = RW'(e_reg[5]);
    assign zx = RW'(e_reg[6]); assign zy = RW'(e_reg[7]); assign zz = RW'(e_reg[8]);
    assign tr = xx + yy + zz;
    always_comb begin
        if (tr > 0) begin
            sel_next = CASE_TRACE; rad_next = tr + one_c;
            n_next[0] = (NW+1)'(zy - yz); n_next[1] = (NW+1)'(xz - zx);
            n_next[2] = (NW+1)'(yx - xy);
        end else if (xx > yy && xx > zz) begin
            sel_next = CASE_XX; rad_next = one_c + xx - yy - zz;
            n_next[0] = (NW+1)'(zy - yz); n_next[1] = (NW+1)'(xy + yx);
            n_next[2] = (NW+1)'(xz + zx);
        end else if (yy > zz) begin
            sel_next = CASE_YY; rad_next = one_c + yy - xx - zz;
            n_next[0] = (NW+1)'(xz - zx); n_next[1] = (NW+1)'(xy + yx);
            n_next[2] = (NW+1)'(zy + yz);
        end else begin
            sel_next = CASE_ZZ; rad_next = one_c + zz - xx - yy;
            n_next[0] = (NW+1)'(yx - xy); n_next[1] = (NW+1)'(xz + zx);
            n_next[2] = (NW+1)'(yz + zy);
        end
    end

    typedef struct packed {
        logic [1:0]    sel;
        logic          degen;
        logic [2:0]    neg;
        logic [NW-1:0] mag0;
        logic [NW-1:0] mag1;
        logic [NW-1:0] mag2;
    } side_t;

    side_t              s2_reg;
    logic [SQW-1:0]     rop_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_reg.sel   <= sel_next;
            s2_reg.degen <= rad_next <= 0;
            s2_reg.neg   <= {n_next[2][NW], n_next[1][NW], n_next[0][NW]};
            s2_reg.mag0  <= NW'(n_next[0][NW] ? -n_next[0] : n_next[0]);
            s2_reg.mag1  <= NW'(n_next[1][NW] ? -n_next[1] : n_next[1]);
            s2_reg.mag2  <= NW'(n_next[2][NW] ? -n_next[2] : n_next[2]);
            rop_reg      <= (rad_next <= 0) ? '0
                          : SQW'({rad_next[RW-2:0], {FRAC_BITS{1'b0}}});
        end
    end

    // Square root: one result bit per stage, restoring method.
    logic [SQW-1:0] sq_rem_reg  [SQI+1];
    logic [SQW-1:0] sq_op_reg   [SQI+1];
    logic [SQI-1:0] sq_root_reg [SQI+1];
    side_t          sq_side_reg [SQI+1];
    always_comb begin
        sq_rem_reg[0]  = '0;
        sq_op_reg[0]   = rop_reg;
        sq_root_reg[0] = '0;
        sq_side_reg[0] = s2_reg;
    end
    for (genvar k = 0; k < SQI; k++) begin : g_sqrt
        logic [SQW+1:0] trial, rem2;
        assign rem2  = {sq_rem_reg[k], sq_op_reg[k][SQW-1 -: 2]};
        assign trial = rem2 - {SQW'(sq_root_reg[k]), 2'b01};
        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_op_reg[k+1]   <= sq_op_reg[k] << 2;
                sq_side_reg[k+1] <= sq_side_reg[k];
                if (!trial[SQW+1]) begin
                    sq_rem_reg[k+1]  <= SQW'(trial);
                    sq_root_reg[k+1] <= {sq_root_reg[k][SQI-2:0], 1'b1};
                end else begin
                    sq_rem_reg[k+1]  <= SQW'(rem2);
                    sq_root_reg[k+1] <= {sq_root_reg[k][SQI-2:0], 1'b0};
                end
            end
        end
    end

    // Divider entry: form s = 2r and the rounded dividends (mag << F) + r.
    logic [DSW-1:0] dv_s_reg   [DVW+1];
    logic [SQI-1:0] dv_pk_reg  [DVW+1];
    side_t          dv_side_reg[DVW+1];
    logic [DVW:0]   dv_num_reg [3][DVW+1];
    logic [RMW-1:0] dv_rem_reg [3][DVW+1];
    logic [DVW-1:0] dv_q_reg   [3][DVW+1];
    logic [SQI-1:0] root_f;
    assign root_f = sq_root_reg[SQI];
    always_comb begin
        dv_s_reg[0]    = {root_f, 1'b0};
        dv_pk_reg[0]   = root_f >> 1;
        dv_side_reg[0] = sq_side_reg[SQI];
        dv_num_reg[0][0] = (DVW+1)'({sq_side_reg[SQI].mag0, {FRAC_BITS{1'b0}}})
                         + (DVW+1)'(root_f);
        dv_num_reg[1][0] = (DVW+1)'({sq_side_reg[SQI].mag1, {FRAC_BITS{1'b0}}})
                         + (DVW+1)'(root_f);
        dv_num_reg[2][0] = (DVW+1)'({sq_side_reg[SQI].mag2, {FRAC_BITS{1'b0}}})
                         + (DVW+1)'(root_f);
        for (int j = 0; j < 3; j++) begin
            dv_rem_reg[j][0] = '0;
            dv_q_reg[j][0]   = '0;
        end
    end
    // The dividend is below 2^(DVW+1); the top quotient bit beyond DVW is always
    // zero for a nonzero divisor of at least 2, which degenerate-free items have.
    // The first stage takes the top two dividend bits, every later stage one more.
    for (genvar k = 0; k < DVW; k++) begin : g_div
        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_s_reg[k+1]    <= dv_s_reg[k];
                dv_pk_reg[k+1]   <= dv_pk_reg[k];
                dv_side_reg[k+1] <= dv_side_reg[k];
            end
        end
        for (genvar j = 0; j < 3; j++) begin : g_lane
            logic [RMW:0] acc, t2;
            assign acc = (k == 0)
                ? (RMW+1)'(dv_num_reg[j][k][DVW:DVW-1])
                : {dv_rem_reg[j][k], dv_num_reg[j][k][DVW-1]};
            assign t2 = acc - (RMW+1)'(dv_s_reg[k]);
            always_ff @(posedge aclk) begin
                if (adv) begin
                    dv_num_reg[j][k+1] <= dv_num_reg[j][k] << 1;
                    if (!t2[RMW] && dv_s_reg[k] != '0) begin
                        dv_rem_reg[j][k+1] <= RMW'(t2);
                        dv_q_reg[j][k+1]   <= {dv_q_reg[j][k][DVW-2:0], 1'b1};
                    end else begin
                        dv_rem_reg[j][k+1] <= RMW'(acc);
                        dv_q_reg[j][k+1]   <= {dv_q_reg[j][k][DVW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // Output stage: apply signs, saturate, place the picked component and zero degenerate items.
    function automatic logic [FIELD_W-1:0] sat_q(input logic [DVW-1:0] q, input logic n);
        logic [FIELD_W-1:0] r;
        begin
            if (n) r = (q > DVW'(131072)) ? 18'h20000 : FIELD_W'(-q);
            else   r = (q > DVW'(131071)) ? 18'h1FFFF : FIELD_W'(q);
            return r;
        end
    endfunction

    side_t              fs;
    logic [FIELD_W-1:0] a_c, b_c, c_c, p_c;
    logic [FIELD_W-1:0] qw_n, qx_n, qy_n, qz_n;
    assign fs  = dv_side_reg[DVW];
    assign a_c = sat_q(dv_q_reg[0][DVW], fs.neg[0]);
    assign b_c = sat_q(dv_q_reg[1][DVW], fs.neg[1]);
    assign c_c = sat_q(dv_q_reg[2][DVW], fs.neg[2]);
    assign p_c = sat_q(DVW'(dv_pk_reg[DVW]), 1'b0);
    always_comb begin
        case (fs.sel)
            CASE_TRACE: begin qw_n = p_c; qx_n = a_c; qy_n = b_c; qz_n = c_c; end
            CASE_XX:    begin qw_n = a_c; qx_n = p_c; qy_n = b_c; qz_n = c_c; end
            CASE_YY:    begin qw_n = a_c; qx_n = b_c; qy_n = p_c; qz_n = c_c; end
            default:    begin qw_n = a_c; qx_n = b_c; qy_n = c_c; qz_n = p_c; end
        endcase
        if (fs.degen) begin
            qw_n = '0; qx_n = '0; qy_n = '0; qz_n = '0;
        end
    end

    logic [79:0] out_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= {5'b0, fs.degen, fs.sel, qz_n, qy_n, qx_n, qw_n};
        end
    end
    assign m_tdata = out_reg;

    unused_r2: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("held result changed");
    deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[74] |-> m_tdata[71:0] == '0)
        else $error("degenerate result not zero");
    ready_a: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");
endmodule
